>>> rtl/bma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boxcar moving average package
// Field widths and controller state type shared across the block.
// ----------------------------------------------------------------------------
package bma_pkg;

   // Fixed widths of the channel fields
   localparam int SAMPLE_W  = 12;
   localparam int AVERAGE_W = 12;

   // Controller state
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_HOLD
   } bma_state_type;

endpackage

>>> rtl/bma_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boxcar moving average channels
// Valid/ready channels for the sample and the average items.
// ----------------------------------------------------------------------------
interface bma_req_if
   import bma_pkg::*;
   ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface bma_rsp_if
   import bma_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [AVERAGE_W-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

>>> rtl/boxcar_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boxcar moving average
// Floor of the mean of the most recent samples, up to WINDOW of them, one average per sample.
// ----------------------------------------------------------------------------
// Flow: one sample in flight; a new sample is accepted only once the previous
//    average is in the output register. The bit-serial divider produces one
//    quotient bit per cycle.
// Reset: synchronous, clears fill count, running sum, controller and output
//    valid; the sample chain holds no reset and is read only once it is full.
// ----------------------------------------------------------------------------
module boxcar_moving_average
   import bma_pkg::*;
#(
   parameter int WINDOW      = 16,
   parameter int SAMPLE_BITS = 12
) (
   input logic     clock,
   input logic     reset,
   bma_req_if.sink   req_ch,
   bma_rsp_if.source rsp_ch
);

   // Sum of WINDOW samples stays below WINDOW * 2**SAMPLE_BITS
   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW);
   localparam int CNT_W = $clog2(WINDOW + 1);
   localparam int EXT_W = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam int QEX_W = (SUM_W > AVERAGE_W) ? SUM_W : AVERAGE_W;
   localparam logic [CNT_W-1:0] WIN_COUNT = CNT_W'(WINDOW);

   bma_state_type state_ff, state_in;

   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [AVERAGE_W-1:0]   rsp_average_ff, rsp_average_in;

   logic                   accept;
   logic                   out_free;
   logic                   load_out;
   logic                   div_done;
   logic [SUM_W-1:0]       quotient;
   logic [QEX_W-1:0]       quotient_ext;
   logic [EXT_W-1:0]       sample_ext;
   logic [SAMPLE_BITS-1:0] sample;
   logic [SAMPLE_BITS-1:0] oldest;
   logic [SAMPLE_BITS-1:0] chain [WINDOW+1];

   // Drop sample bits above SAMPLE_BITS
   assign sample_ext = EXT_W'(req_ch.sample);
   assign sample     = sample_ext[SAMPLE_BITS-1:0];

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // ---------------------------------------------------------------------
   // Sample chain: advance one cell per accepted item; the last cell holds
   // the sample that leaves the window once the window is full.
   // ---------------------------------------------------------------------
   assign chain[0] = sample;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      bma_cell #(
         .WIDTH (SAMPLE_BITS)
      ) u_cell (
         .clock    (clock),
         .advance  (accept),
         .data_in  (chain[i]),
         .data_out (chain[i+1])
      );
   end

   assign oldest = chain[WINDOW];

   // ---------------------------------------------------------------------
   // Running sum and fill count: add the new sample, and once full also
   // retire the oldest one; the count saturates at WINDOW.
   // ---------------------------------------------------------------------
   always_comb begin
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (accept) begin
         if (fill_ff < WIN_COUNT) begin
            fill_in = fill_ff + CNT_W'(1);
            sum_in  = sum_ff + SUM_W'(sample);
         end else begin
            sum_in  = sum_ff - SUM_W'(oldest) + SUM_W'(sample);
         end
      end
   end

   // Divide the updated sum by the updated count; count is never zero here
   bma_divider #(
      .NUM_W (SUM_W),
      .DEN_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .dividend (sum_in),
      .divisor  (fill_in),
      .done     (div_done),
      .quotient (quotient)
   );

   // ---------------------------------------------------------------------
   // Controller: accept in idle, wait for the quotient, hold it until the
   // output register has room.
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = out_free ? ST_IDLE : ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ch.ready = 1'b0;
      load_out     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_DIV: begin
            load_out = div_done && out_free;
         end
         ST_HOLD: begin
            load_out = out_free;
         end
         default: begin
            load_out = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Output register: load a finished average, drop valid once taken.
   // ---------------------------------------------------------------------
   assign quotient_ext = QEX_W'(quotient);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_average_in = rsp_average_ff;
      if (load_out) begin
         rsp_valid_in   = 1'b1;
         rsp_average_in = quotient_ext[AVERAGE_W-1:0];
      end else if (rsp_ch.ready) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.average = rsp_average_ff;

endmodule

>>> rtl/bma_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boxcar moving average delay cell
// One sample slot of the window; hands its sample to the next cell on advance.
// ----------------------------------------------------------------------------
module bma_cell #(
   parameter int WIDTH = 12
) (
   input  logic             clock,
   input  logic             advance,
   input  logic [WIDTH-1:0] data_in,
   output logic [WIDTH-1:0] data_out
);

   logic [WIDTH-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;

endmodule

>>> rtl/bma_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boxcar moving average divider
// Restoring divider, one quotient bit per cycle, done pulses after last bit.
// ----------------------------------------------------------------------------
module bma_divider #(
   parameter int NUM_W = 16,
   parameter int DEN_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);

   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    rem_shift;
   logic [DEN_W:0]    rem_diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[NUM_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      step_in   = step_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // Remainder stays below the divisor, so the difference fits DEN_W bits
         if (rem_shift >= {1'b0, den_ff}) begin
            rem_in = rem_diff[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/bma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boxcar moving average checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module bma_checker
   import bma_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [AVERAGE_W-1:0] rsp_average
);

   // Hold a stalled average item
   a_rsp_hold_valid : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("average item dropped while stalled");

   a_rsp_hold_data : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_average))
      else $error("average changed while stalled");

   // One item in flight: no accept right after an accept
   a_one_in_flight : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("sample accepted while previous one is in progress");

   // Reset leaves the block idle and empty
   a_reset_idle : assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule

bind boxcar_moving_average bma_checker u_bma_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_average (rsp_ch.average)
);

>>> test/boxcar_moving_average_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Boxcar moving average testbench
// Streams directed and random converter samples into the filter, predicts
// each windowed mean in step with every accepted sample and checks every
// returned average in order. Both sides idle in random bursts, and the
// receiver holds off for long stretches so that the filter backs up.
// ----------------------------------------------------------------------------
module boxcar_moving_average_test;
   import bma_pkg::*;

   localparam int WINDOW      = 16;
   localparam int SAMPLE_BITS = 12;
   localparam int COUNT_W     = $clog2(WINDOW + 1);
   localparam int SUM_W       = SAMPLE_BITS + $clog2(WINDOW);
   localparam int RANDOM_ITEMS = 800;
   localparam int QUIET_TAIL   = 100;   // last items run with no idling
   localparam int HOLD_CYCLES  = 300;   // length of one long receiver hold-off
   localparam int DRAIN_CYCLES = 2 * (SUM_W + 2);
   localparam int STALL_LIMIT  = 4000;  // cycles with no item moving on either side
   localparam int REPORT_MAX   = 10;

   // Clock, reset and driven copies of the channel inputs, known from time 0
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                drv_valid  = 1'b0;
   logic [SAMPLE_W-1:0] drv_sample = '0;
   logic                drv_ready  = 1'b0;

   bma_req_if req_if ();
   bma_rsp_if rsp_if ();

   assign req_if.valid  = drv_valid;
   assign req_if.sample = drv_sample;
   assign rsp_if.ready  = drv_ready;

   boxcar_moving_average #(
      .WINDOW      (WINDOW),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if.sink),
      .rsp_ch (rsp_if.source)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Window predictor: own copy of the ring, slot, fill count and sum
   // ------------------------------------------------------------------------
   logic [SAMPLE_W-1:0] win_ring [WINDOW];
   logic [3:0]          win_slot  = '0;
   logic [COUNT_W-1:0]  win_fill  = '0;
   logic [SUM_W-1:0]    win_sum   = '0;

   // Fold one sample into the window and return the floor of its mean
   task automatic fold_sample(input logic [SAMPLE_W-1:0] smp,
                              output logic [AVERAGE_W-1:0] mean);
      logic [SUM_W-1:0] quot;
      if (win_fill < WINDOW) begin
         // Ring still filling: grow the sum and the divisor
         win_sum  = win_sum + SUM_W'(smp);
         win_fill = win_fill + COUNT_W'(1);
      end else begin
         // Ring full: the slot about to be written holds the oldest sample
         win_sum = win_sum - SUM_W'(win_ring[win_slot]) + SUM_W'(smp);
      end
      win_ring[win_slot] = smp;
      // Wrap the slot at WINDOW, also while filling
      win_slot = (win_slot == WINDOW - 1) ? '0 : win_slot + 4'(1);
      quot = win_sum / SUM_W'(win_fill);
      mean = quot[AVERAGE_W-1:0];
   endtask

   // ------------------------------------------------------------------------
   // Scoreboard state
   // ------------------------------------------------------------------------
   logic [SAMPLE_W-1:0]  sample_queue [$];   // samples not yet offered
   logic [AVERAGE_W-1:0] mean_queue [$];     // averages still owed by the block
   int  n_items      = 0;   // total samples to send
   int  n_sent       = 0;   // samples accepted by the block
   int  n_checked    = 0;   // averages compared
   int  n_mismatch   = 0;
   int  n_holdoffs   = 0;
   int  quiet_cycles = 0;
   logic req_fire    = 1'b0;
   logic tail_quiet  = 1'b0;
   logic hold_off    = 1'b0;
   int  src_gap      = 0;
   int  snk_gap      = 0;

   // ------------------------------------------------------------------------
   // Sender: offer samples at the falling edge, hold each until accepted
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else if (drv_valid && !req_fire) begin
         // Hold the offered item until the block takes it
         drv_valid <= 1'b1;
      end else if (src_gap > 0) begin
         drv_valid <= 1'b0;
         src_gap   <= src_gap - 1;
      end else if (sample_queue.size() == 0) begin
         drv_valid <= 1'b0;
      end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
         // Start an idle burst of random length
         drv_valid <= 1'b0;
         src_gap   <= $urandom_range(0, 15);
      end else begin
         drv_valid  <= 1'b1;
         drv_sample <= sample_queue.pop_front();
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: drive ready at the falling edge, with idle bursts and hold-offs
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || hold_off) begin
         drv_ready <= 1'b0;
      end else if (snk_gap > 0) begin
         drv_ready <= 1'b0;
         snk_gap   <= snk_gap - 1;
      end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
         drv_ready <= 1'b0;
         snk_gap   <= $urandom_range(0, 15);
      end else begin
         drv_ready <= 1'b1;
      end
   end

   // Long receiver hold-offs, timed here, while the sender keeps offering
   initial begin
      while (n_sent < 120) @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off   = 1'b0;
      n_holdoffs = n_holdoffs + 1;
      while (n_sent < 450) @(posedge clock);
      hold_off = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off   = 1'b0;
      n_holdoffs = n_holdoffs + 1;
   end

   // ------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge, predict and check
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      logic [AVERAGE_W-1:0] mean;
      logic [AVERAGE_W-1:0] want;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            fold_sample(req_if.sample, mean);
            mean_queue.push_back(mean);
            n_sent = n_sent + 1;
            if (n_sent >= n_items - QUIET_TAIL) tail_quiet = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (mean_queue.size() == 0) begin
               // Drop into the mismatch count: nothing was owed
               n_mismatch = n_mismatch + 1;
               if (n_mismatch <= REPORT_MAX)
                  $display("unexpected average %0d with none pending", rsp_if.average);
            end else begin
               want      = mean_queue.pop_front();
               n_checked = n_checked + 1;
               if (rsp_if.average !== want) begin
                  n_mismatch = n_mismatch + 1;
                  if (n_mismatch <= REPORT_MAX)
                     $display("average %0d: expected %0d, got %0d",
                              n_checked, want, rsp_if.average);
               end
            end
         end
         // Watchdog: count cycles in which no item moves on either side
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------------
   initial begin
      int pick;
      // Directed: first sample after reset, a full window of the largest
      // sample (largest sum), then wrap through extremes and small values
      sample_queue.push_back(12'hFFF);
      repeat (WINDOW - 1) sample_queue.push_back(12'hFFF);
      sample_queue.push_back(12'h000);
      sample_queue.push_back(12'hFFF);
      sample_queue.push_back(12'h001);
      sample_queue.push_back(12'h800);
      sample_queue.push_back(12'hFFE);
      sample_queue.push_back(12'h555);
      sample_queue.push_back(12'hAAA);
      sample_queue.push_back(12'h000);
      sample_queue.push_back(12'h000);
      // Random: mostly uniform, with extremes and small values mixed in
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         pick = $urandom_range(0, 9);
         case (pick)
            6: begin
               sample_queue.push_back(12'h000);
            end
            7: begin
               sample_queue.push_back(12'hFFF);
            end
            8: begin
               sample_queue.push_back(SAMPLE_W'($urandom_range(0, 15)));
            end
            default: begin
               sample_queue.push_back(SAMPLE_W'($urandom_range(0, 4095)));
            end
         endcase
      end
      n_items = sample_queue.size();

      // Hold reset while the clock runs, then release it at a falling edge
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Advance until every sample is in and every average has returned
      while (n_sent < n_items || mean_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d samples sent, %0d averages checked, %0d mismatches",
               n_sent, n_checked, n_mismatch);
      $display("%0d long receiver hold-offs of %0d cycles with burst idling on both sides",
               n_holdoffs, HOLD_CYCLES);
      if (n_mismatch == 0 && mean_queue.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/bma_pkg.sv
rtl/bma_if.sv
rtl/bma_cell.sv
rtl/bma_divider.sv
rtl/boxcar_moving_average.sv
rtl/bma_checker.sv
test/boxcar_moving_average_test.sv
